/* rtl/csrspmv_pkg.sv */
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared types and constants for the CSR sparse matrix times vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package csrspmv_pkg;

	// field widths
	localparam int CMD_W   = 2;
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 32;
	localparam int ROW_W   = 16;
	localparam int ACC_W   = 2 * VALUE_W;

	// default vector store depth
	localparam int VEC_DEPTH_DEF = 1024;

	// fraction bits dropped in q32.32 to q16.16 conversion
	localparam int FRAC_SHIFT = 16;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_MAC  = 2'd1,
		CMD_END  = 2'd2
	} cmd_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_EMIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic wr_vec;
		logic rd_vec;
		logic mul;
		logic acc;
		logic emit;
	} ctrl_t;

	// status from datapath to controller
	typedef struct packed {
		logic slot_free;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/csrspmv_ram.sv */
// ----------------------------------------------------------------------------
// csrspmv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/csrspmv_ctrl.sv */
// ----------------------------------------------------------------------------
// csrspmv_ctrl
// Sequencer: takes one input beat, then writes the vector store or steps the
// datapath through read, multiply, accumulate or result emit.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [csrspmv_pkg::CMD_W-1:0]   in_cmd,
	input  csrspmv_pkg::stat_t              stat,
	output csrspmv_pkg::ctrl_t              ctl
);

	import csrspmv_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_cmd)
						CMD_LOAD: ctl.wr_vec = 1'b1;
						CMD_MAC: begin
							ctl.rd_vec = 1'b1;
							state_d    = S_MUL;
						end
						CMD_END: state_d = S_EMIT;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				ctl.acc = 1'b1;
				state_d = S_IDLE;
			end
			S_EMIT: begin
				if (stat.slot_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// multiply always followed by accumulate
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |=> state_q == S_ACC)
		else $error("multiply step not followed by accumulate");

	// an end of row beat always leads to the emit state
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_cmd == CMD_END |=> state_q == S_EMIT)
		else $error("end of row did not enter emit");

	// no beat taken while a nonzero is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_vec |=> in_stall)
		else $error("input taken during multiply-accumulate");

endmodule

`default_nettype wire

/* rtl/csrspmv_dp.sv */
// ----------------------------------------------------------------------------
// csrspmv_dp
// Datapath: vector store, multiplier, saturating Q32.32 accumulator,
// rounding output conversion, row counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_dp #(
	parameter int VEC_DEPTH = csrspmv_pkg::VEC_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  csrspmv_pkg::ctrl_t                     ctl,
	output csrspmv_pkg::stat_t                     stat,
	input  logic [csrspmv_pkg::INDEX_W-1:0]        in_index,
	input  logic signed [csrspmv_pkg::VALUE_W-1:0] in_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [csrspmv_pkg::ROW_W-1:0]          row_number,
	output logic signed [csrspmv_pkg::VALUE_W-1:0] row_value,
	output logic                                   saturated
);

	import csrspmv_pkg::*;

	localparam int AW = $clog2(VEC_DEPTH);
	localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;
	localparam int QW = ACC_W + 1 - FRAC_SHIFT;

	logic [XW-1:0]              idx_x;
	logic [AW-1:0]              addr;
	logic                       in_range;
	logic [VALUE_W-1:0]         rdata;
	logic signed [VALUE_W-1:0]  val_q;
	logic                       range_q;
	logic signed [VALUE_W-1:0]  vec_elem;
	logic signed [ACC_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       ovf_q;
	logic [ROW_W-1:0]           row_cnt_q;
	logic signed [ACC_W:0]      sum;
	logic signed [ACC_W:0]      rnd;
	logic signed [QW-1:0]       q;
	logic                       sat_hi;
	logic                       sat_lo;
	logic signed [VALUE_W-1:0]  conv;
	logic                       out_valid_q;
	logic [ROW_W-1:0]           out_row_q;
	logic signed [VALUE_W-1:0]  out_val_q;
	logic                       out_sat_q;

	// address and range check
	assign idx_x    = XW'(in_index);
	assign addr     = idx_x[AW-1:0];
	assign in_range = 32'(in_index) < 32'(VEC_DEPTH);

	csrspmv_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (VEC_DEPTH)
	) u_vec_ram (
		.clk   (clk),
		.we    (ctl.wr_vec && in_range),
		.waddr (addr),
		.wdata (in_value),
		.re    (ctl.rd_vec),
		.raddr (addr),
		.rdata (rdata)
	);

	// nonzero value and range held over the ram read
	always_ff @(posedge clk) begin
		if (ctl.rd_vec) begin
			val_q   <= in_value;
			range_q <= in_range;
		end
	end

	// out of range columns read as zero
	assign vec_elem = range_q ? $signed(rdata) : '0;

	// product register
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= val_q * vec_elem;
		end
	end

	// saturating add, one guard bit
	assign sum = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};

	// round half up, then clamp to 32 bits
	assign rnd    = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(1 << (FRAC_SHIFT - 1));
	assign q      = rnd[ACC_W:FRAC_SHIFT];
	assign sat_hi = !q[QW-1] && (q[QW-2:VALUE_W-1] != '0);
	assign sat_lo = q[QW-1] && (q[QW-2:VALUE_W-1] != '1);

	always_comb begin
		priority if (sat_hi) begin
			conv = {1'b0, {(VALUE_W-1){1'b1}}};
		end else if (sat_lo) begin
			conv = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			conv = q[VALUE_W-1:0];
		end
	end

	// accumulator, overflow flag and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			row_cnt_q <= '0;
		end else if (ctl.emit) begin
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			row_cnt_q <= row_cnt_q + 1'b1;
		end else if (ctl.acc) begin
			if (sum[ACC_W] != sum[ACC_W-1]) begin
				acc_q <= sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
				                    : {1'b0, {(ACC_W-1){1'b1}}};
				ovf_q <= 1'b1;
			end else begin
				acc_q <= sum[ACC_W-1:0];
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_row_q <= row_cnt_q;
			out_val_q <= conv;
			out_sat_q <= ovf_q || sat_hi || sat_lo;
		end
	end

	assign stat.slot_free = !out_valid_q || !out_stall;
	assign out_valid      = out_valid_q;
	assign row_number     = out_row_q;
	assign row_value      = out_val_q;
	assign saturated      = out_sat_q;

	// a result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || !out_stall))
		else $error("emit over a pending result");

	// row state cleared after emit
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> (acc_q == '0 && !ovf_q))
		else $error("row state not cleared after emit");

	// row counter steps by one per emitted row
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> row_cnt_q == $past(row_cnt_q) + ROW_W'(1))
		else $error("row counter did not advance");

	// out of range column gives a zero product
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mul && !range_q |=> prod_q == '0)
		else $error("out of range column contributed");

endmodule

`default_nettype wire

/* rtl/csr_sparse_matrix_vector_multiply.sv */
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// CSR sparse matrix times dense vector, one row at a time, Q16.16 data with
// a saturating Q32.32 accumulator.
// ----------------------------------------------------------------------------
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-------------------------------
// in      | sink      | in_valid/in_stall  | cmd, index, value
// out     | source    | out_valid/out_stall| row_number, row_value, saturated
//
// a vector load beat is one ram write
// a nonzero beat steps through ram read, multiply, accumulate add
// an end of row beat waits in the emit state while the output register is full
// the output register lets new beats in while a row result waits
// reset clears control and the row accumulator; the vector store is not
// cleared and holds garbage until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
	parameter int VEC_DEPTH = csrspmv_pkg::VEC_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [csrspmv_pkg::CMD_W-1:0]          cmd,
	input  logic [csrspmv_pkg::INDEX_W-1:0]        index,
	input  logic signed [csrspmv_pkg::VALUE_W-1:0] value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [csrspmv_pkg::ROW_W-1:0]          row_number,
	output logic signed [csrspmv_pkg::VALUE_W-1:0] row_value,
	output logic                                   saturated
);

	import csrspmv_pkg::*;

	ctrl_t ctl;
	stat_t stat;

	// sequencer
	csrspmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_cmd   (cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	// arithmetic and storage
	csrspmv_dp #(
		.VEC_DEPTH (VEC_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.in_index   (index),
		.in_value   (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_number (row_number),
		.row_value  (row_value),
		.saturated  (saturated)
	);

endmodule

`default_nettype wire
